// ----- hw/rtl/voxel_visible_face_emitter_defines.svh -----
// Assertion helpers shared by the voxel face emitter RTL.
`ifndef VOXEL_VISIBLE_FACE_EMITTER_DEFINES_SVH
`define VOXEL_VISIBLE_FACE_EMITTER_DEFINES_SVH

// Same-cycle implication, checked on clk and held off while rst_n is low.
`define VVFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off while rst_n is low.
`define VVFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/vvfe_pkg.sv -----
package vvfe_pkg;

  localparam int unsigned COORD_W      = 4;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned RGB_W        = 3 * COLOR_W;
  localparam int unsigned VOXEL_W      = RGB_W + 1;
  localparam int unsigned SIZE_W       = 5;
  localparam int unsigned DIR_W        = 3;
  localparam int unsigned FACE_N       = 6;
  localparam int unsigned NBR_N        = 6;
  localparam int unsigned COORD_SPAN   = 16;
  localparam int unsigned SIDE_MAX_DEF = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned IN_DATA_W    = 40;
  localparam int unsigned OUT_DATA_W   = 40;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Operation codes carried on in_tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Z = 2'd2;

  // Face codes.
  localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd2;
  localparam logic [DIR_W-1:0] DIR_TOP    = 3'd3;
  localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_BACK   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELF,
    ST_NBR,
    ST_EMIT
  } back_state_t;

  // One queued command. bnd is indexed by face code, nbr_ok by neighbor
  // slot (right, top, back, left, bottom, front).
  typedef struct packed {
    logic                 op;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   z;
    logic [VOXEL_W-1:0]   voxel;
    logic [FACE_N-1:0]    bnd;
    logic [NBR_N-1:0]     nbr_ok;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [DIR_W-1:0]   dir;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } face_t;

  // Face code that belongs to each neighbor slot.
  function automatic logic [DIR_W-1:0] nbr_dir(input logic [2:0] k);
    logic [DIR_W-1:0] d;
    case (k)
      3'd0:    d = DIR_RIGHT;
      3'd1:    d = DIR_TOP;
      3'd2:    d = DIR_BACK;
      3'd3:    d = DIR_LEFT;
      3'd4:    d = DIR_BOTTOM;
      3'd5:    d = DIR_FRONT;
      default: d = DIR_LEFT;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/vvfe_ram.sv -----
module vvfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/vvfe_fifo.sv -----
module vvfe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign valid    = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/vvfe_front.sv -----
module vvfe_front import vvfe_pkg::*; #(
  parameter int unsigned SIDE_MAX = SIDE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  // Largest usable extent: the store side and the coordinate width both bound it.
  localparam int unsigned LIM = (SIDE_MAX < COORD_SPAN) ? SIDE_MAX : COORD_SPAN;

  logic [SIZE_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [SIZE_W-1:0]  sx, sy, sz;
  logic [SIZE_W-1:0]  xe, ye, ze;
  logic [COORD_W-1:0] px, py, pz;
  logic               in_range;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(LIM)) begin
      r = SIZE_W'(LIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SIZE_X: size_x_r <= cfg_wdata;
        REG_SIZE_Y: size_y_r <= cfg_wdata;
        REG_SIZE_Z: size_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sx = eff_size(size_x_r);
  assign sy = eff_size(size_y_r);
  assign sz = eff_size(size_z_r);

  assign px = in_tdata[3:0];
  assign py = in_tdata[7:4];
  assign pz = in_tdata[11:8];
  assign xe = {1'b0, px};
  assign ye = {1'b0, py};
  assign ze = {1'b0, pz};

  assign in_range  = (xe < sx) && (ye < sy) && (ze < sz);
  assign in_tready = !q_full;
  // Items outside the grid are consumed and dropped here.
  assign q_push    = in_tvalid && in_tready && in_range;

  always_comb begin
    q_cmd.op    = in_tuser;
    q_cmd.x     = px;
    q_cmd.y     = py;
    q_cmd.z     = pz;
    // Stored as solid flag on top, then red, green and blue.
    q_cmd.voxel = {in_tdata[12], in_tdata[20:13], in_tdata[28:21], in_tdata[36:29]};

    // At most one boundary face per axis; the low side wins for an extent of one.
    q_cmd.bnd             = '0;
    q_cmd.bnd[DIR_LEFT]   = (px == '0);
    q_cmd.bnd[DIR_RIGHT]  = (px != '0) && (xe == sx - SIZE_W'(1));
    q_cmd.bnd[DIR_BOTTOM] = (py == '0);
    q_cmd.bnd[DIR_TOP]    = (py != '0) && (ye == sy - SIZE_W'(1));
    q_cmd.bnd[DIR_FRONT]  = (pz == '0);
    q_cmd.bnd[DIR_BACK]   = (pz != '0) && (ze == sz - SIZE_W'(1));

    q_cmd.nbr_ok[0] = (xe + SIZE_W'(1)) < sx;
    q_cmd.nbr_ok[1] = (ye + SIZE_W'(1)) < sy;
    q_cmd.nbr_ok[2] = (ze + SIZE_W'(1)) < sz;
    q_cmd.nbr_ok[3] = (px != '0);
    q_cmd.nbr_ok[4] = (py != '0);
    q_cmd.nbr_ok[5] = (pz != '0);
  end

endmodule

// ----- hw/rtl/vvfe_back.sv -----
module vvfe_back import vvfe_pkg::*; #(
  parameter int unsigned SIDE_MAX = SIDE_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  input  cmd_t                                   q_cmd,
  output logic                                   q_pop,
  output logic                                   ram_we,
  output logic [$clog2(SIDE_MAX**3)-1:0]         ram_waddr,
  output logic [VOXEL_W-1:0]                     ram_wdata,
  output logic [$clog2(SIDE_MAX**3)-1:0]         ram_raddr,
  input  logic [VOXEL_W-1:0]                     ram_rdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output face_t                                  out_face,
  output logic                                   out_tlast
);

  localparam int unsigned PLANE  = SIDE_MAX * SIDE_MAX;
  localparam int unsigned AW     = $clog2(PLANE * SIDE_MAX);
  localparam int unsigned PEND_W = 2 * FACE_N;
  localparam int unsigned PICK_W = $clog2(PEND_W);

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [RGB_W-1:0]   color_r, color_nxt;
  logic [NBR_N-1:0]   int_r, int_nxt;
  logic [2:0]         nb_r, nb_nxt;
  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  face_t              out_face_r, out_face_nxt;
  logic               out_last_r, out_last_nxt;

  logic               nb_empty;
  logic [NBR_N-1:0]   int_upd;
  logic [PEND_W-1:0]  pend_init;
  logic [PICK_W-1:0]  pick;
  logic [PEND_W-1:0]  pend_clr;
  logic               last_pick;
  logic [DIR_W-1:0]   pick_dir;
  logic               out_load;

  function automatic logic [AW-1:0] voxel_addr(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [COORD_W-1:0] z);
    return AW'(x) * AW'(PLANE) + AW'(y) * AW'(SIDE_MAX) + AW'(z);
  endfunction

  // Address of neighbor slot k; a slot without a neighbor reads the voxel itself.
  function automatic logic [AW-1:0] nbr_addr(input cmd_t c, input logic [2:0] k);
    logic [COORD_W-1:0] nx, ny, nz;
    nx = c.x;
    ny = c.y;
    nz = c.z;
    if (c.nbr_ok[k]) begin
      case (k)
        3'd0:    nx = c.x + COORD_W'(1);
        3'd1:    ny = c.y + COORD_W'(1);
        3'd2:    nz = c.z + COORD_W'(1);
        3'd3:    nx = c.x - COORD_W'(1);
        3'd4:    ny = c.y - COORD_W'(1);
        3'd5:    nz = c.z - COORD_W'(1);
        default: ;
      endcase
    end
    return voxel_addr(nx, ny, nz);
  endfunction

  function automatic logic [PICK_W-1:0] lowest_set(input logic [PEND_W-1:0] v);
    logic [PICK_W-1:0] idx;
    idx = '0;
    for (int i = PEND_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = PICK_W'(i);
      end
    end
    return idx;
  endfunction

  // Pending faces: boundary faces by face code in the low half, interior
  // faces by neighbor slot in the high half, so lowest-first is emit order.
  assign nb_empty  = cmd_r.nbr_ok[nb_r] && !ram_rdata[VOXEL_W-1];
  assign int_upd   = int_r | (NBR_N'(nb_empty) << nb_r);
  assign pend_init = {int_upd, cmd_r.bnd};
  assign pick      = lowest_set(pend_r);
  assign pend_clr  = pend_r & ~(PEND_W'(1) << pick);
  assign last_pick = (pend_clr == '0);
  assign pick_dir  = (pick < PICK_W'(FACE_N)) ? DIR_W'(pick)
                                              : nbr_dir(3'(pick - PICK_W'(FACE_N)));
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_cmd.op == OP_QUERY) begin
          state_nxt = ST_SELF;
        end
      end
      ST_SELF: begin
        state_nxt = ram_rdata[VOXEL_W-1] ? ST_NBR : ST_IDLE;
      end
      ST_NBR: begin
        if (nb_r == 3'(NBR_N - 1)) begin
          state_nxt = (pend_init != '0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_load && last_pick) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = voxel_addr(q_cmd.x, q_cmd.y, q_cmd.z);
    ram_wdata = q_cmd.voxel;
    ram_raddr = voxel_addr(q_cmd.x, q_cmd.y, q_cmd.z);
    cmd_nxt   = cmd_r;
    color_nxt = color_r;
    int_nxt   = int_r;
    nb_nxt    = nb_r;
    pend_nxt  = pend_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          int_nxt = '0;
          ram_we  = (q_cmd.op == OP_LOAD);
        end
      end
      ST_SELF: begin
        color_nxt = ram_rdata[RGB_W-1:0];
        ram_raddr = nbr_addr(cmd_r, 3'd0);
        nb_nxt    = 3'd0;
      end
      ST_NBR: begin
        int_nxt  = int_upd;
        pend_nxt = pend_init;
        if (nb_r != 3'(NBR_N - 1)) begin
          nb_nxt    = nb_r + 3'd1;
          ram_raddr = nbr_addr(cmd_r, nb_r + 3'd1);
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          pend_nxt = pend_clr;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_face_nxt  = out_face_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_face_nxt.x     = cmd_r.x;
      out_face_nxt.y     = cmd_r.y;
      out_face_nxt.z     = cmd_r.z;
      out_face_nxt.dir   = pick_dir;
      out_face_nxt.red   = color_r[RGB_W-1 -: COLOR_W];
      out_face_nxt.green = color_r[COLOR_W +: COLOR_W];
      out_face_nxt.blue  = color_r[COLOR_W-1:0];
      out_last_nxt       = last_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    color_r    <= color_nxt;
    int_r      <= int_nxt;
    nb_r       <= nb_nxt;
    pend_r     <= pend_nxt;
    out_face_r <= out_face_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_face   = out_face_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hw/rtl/voxel_visible_face_emitter.sv -----
// Load: the voxel is written to the store as the back end takes the load from the queue.
// Query: the faces of a visible voxel leave one per cycle while out_tready is held high.
// The back end handles one command at a time through the single read port of the
// voxel memory: a query reads its own voxel, then, if it is solid, its six
// neighbors, and only then emits its faces.
// Synchronous active-low reset clears control and sets all sizes to 16;
// the voxel memory is not cleared.
`include "voxel_visible_face_emitter_defines.svh"

module voxel_visible_face_emitter import vvfe_pkg::*; #(
  parameter int unsigned SIDE_MAX = SIDE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, pos_z, solid_in, red_in, green_in, blue_in, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // face_x, face_y, face_z, face_dir, red_out, green_out, blue_out, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // last_face
  output logic                  out_tlast
);

  localparam int unsigned DEPTH = SIDE_MAX ** 3;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic                 q_push, q_full, q_valid, q_pop;
  cmd_t                 q_cmd_in, q_cmd_out;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [VOXEL_W-1:0]   ram_wdata, ram_rdata;
  face_t                out_face;

  vvfe_front #(
    .SIDE_MAX (SIDE_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd_in)
  );

  vvfe_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_cmd_out),
    .valid     (q_valid)
  );

  vvfe_back #(
    .SIDE_MAX (SIDE_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd_out),
    .q_pop      (q_pop),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_face   (out_face),
    .out_tlast  (out_tlast)
  );

  vvfe_ram #(
    .WIDTH (VOXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The first field sits in the lowest bits.
  assign out_tdata = {1'b0, out_face.blue, out_face.green, out_face.red, out_face.dir,
                      out_face.z, out_face.y, out_face.x};

  // A load reaches the store only as it leaves the queue.
  `VVFE_ASSERT_NOW(a_write_from_queue, ram_we, q_pop && q_cmd_out.op == OP_LOAD,
                   "voxel write without a queued load")
  // A queued transaction is visible to the back end on the next cycle.
  `VVFE_ASSERT_NEXT(a_push_visible, q_push, q_valid,
                    "queue empty after a push")
  // Faces of one query leave back to back when the consumer keeps up.
  `VVFE_ASSERT_NEXT(a_faces_contiguous, out_tvalid && out_tready && !out_tlast, out_tvalid,
                    "gap inside a face burst")

endmodule
